// ===== rtl/core/fbd_pkg.sv =====
package fbd_pkg;

    // widths of the transaction fields
    localparam int unsigned WORD_W = 36;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned BYTE_W = 8;
    // stored bits: at most four characters, or a lead nibble plus three raw bytes
    localparam int unsigned ACC_W  = 28;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // special file bytes
    localparam logic [BYTE_W-1:0] BYTE_LF       = 8'o012;
    localparam logic [BYTE_W-1:0] BYTE_CR       = 8'o015;
    localparam logic [BYTE_W-1:0] BYTE_RUBOUT   = 8'o177;
    localparam logic [BYTE_W-1:0] BYTE_ESC_RUB  = 8'o207;
    localparam logic [BYTE_W-1:0] BYTE_ESC_LF   = 8'o212;
    localparam logic [BYTE_W-1:0] BYTE_ESC_CR   = 8'o215;
    localparam logic [BYTE_W-1:0] BYTE_ESC_LAST = 8'o355;
    localparam logic [BYTE_W-1:0] BYTE_CR_ONLY  = 8'o356;
    localparam logic [BYTE_W-1:0] BYTE_RUB_ONLY = 8'o357;
    localparam logic [BYTE_W-1:0] BYTE_LEAD_LO  = 8'o360;

    // characters placed in words
    localparam logic [CHAR_W-1:0] CH_BEL = 7'o007;
    localparam logic [CHAR_W-1:0] CH_LF  = 7'o012;
    localparam logic [CHAR_W-1:0] CH_CR  = 7'o015;
    localparam logic [CHAR_W-1:0] CH_RUB = 7'o177;

    // character counts
    localparam logic [2:0] CNT_FULL  = 3'd5;
    localparam logic [2:0] CNT_OVER  = 3'd6;
    // raw bytes owed after a lead byte
    localparam logic [2:0] RAW_BYTES = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] word_value;
        logic              word_valid;
        logic              end_flag;
        logic              format_error;
    } t_out_item;

    // decoded view of one file byte
    typedef struct packed {
        logic              is_lead;
        logic              two_chars;
        logic [CHAR_W-1:0] char_a;
        logic [CHAR_W-1:0] char_b;
    } t_char_map;

    // engine result for one processed transaction
    typedef struct packed {
        logic      has_result;
        t_out_item item;
    } t_engine_res;

endpackage

// ===== rtl/core/fbd_char_map.sv =====
module fbd_char_map import fbd_pkg::*; (
    input  logic [BYTE_W-1:0] i_byte,
    output t_char_map         o_map
);

    // byte to one or two characters, or binary lead
    always_comb begin
        o_map.is_lead   = 1'b0;
        o_map.two_chars = 1'b0;
        o_map.char_a    = i_byte[CHAR_W-1:0];
        o_map.char_b    = '0;
        if (i_byte >= BYTE_LEAD_LO) begin
            o_map.is_lead = 1'b1;
        end else if (i_byte == BYTE_LF) begin
            o_map.two_chars = 1'b1;
            o_map.char_a    = CH_CR;
            o_map.char_b    = CH_LF;
        end else if (i_byte == BYTE_CR) begin
            o_map.char_a = CH_LF;
        end else if (i_byte < BYTE_RUBOUT) begin
            o_map.char_a = i_byte[CHAR_W-1:0];
        end else if (i_byte == BYTE_RUBOUT) begin
            o_map.two_chars = 1'b1;
            o_map.char_a    = CH_RUB;
            o_map.char_b    = CH_BEL;
        end else if (i_byte == BYTE_ESC_RUB) begin
            o_map.two_chars = 1'b1;
            o_map.char_a    = CH_RUB;
            o_map.char_b    = CH_RUB;
        end else if (i_byte == BYTE_ESC_LF) begin
            o_map.two_chars = 1'b1;
            o_map.char_a    = CH_RUB;
            o_map.char_b    = CH_CR;
        end else if (i_byte == BYTE_ESC_CR) begin
            o_map.two_chars = 1'b1;
            o_map.char_a    = CH_RUB;
            o_map.char_b    = CH_LF;
        end else if (i_byte <= BYTE_ESC_LAST) begin
            // escape then the byte less 0200
            o_map.two_chars = 1'b1;
            o_map.char_a    = CH_RUB;
            o_map.char_b    = i_byte[CHAR_W-1:0];
        end else if (i_byte == BYTE_CR_ONLY) begin
            o_map.char_a = CH_CR;
        end else begin
            o_map.char_a = CH_RUB;
        end
    end

endmodule

// ===== rtl/core/fbd_word_engine.sv =====
module fbd_word_engine import fbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_proc,
    input  t_in_item    i_item,
    output t_engine_res o_res
);

    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [2:0]        r_cnt, n_cnt;
    logic [CHAR_W-1:0] r_carry_char, n_carry_char;
    logic              r_carry_valid, n_carry_valid;
    logic [2:0]        r_left, n_left;
    logic              r_failed, n_failed;

    t_char_map          map;
    logic [2:0]         e_cnt;
    logic [ACC_W-1:0]   e_acc;
    logic [41:0]        wide;
    logic [2:0]         sum_cnt;
    logic [WORD_W-1:0]  wide_b;

    fbd_char_map u_map (
        .i_byte (i_item.byte_value),
        .o_map  (map)
    );

    // accumulator as seen after a carried character is taken in
    always_comb begin
        e_cnt = r_carry_valid ? 3'd1 : r_cnt;
        if (r_carry_valid) begin
            e_acc = {{(ACC_W-CHAR_W){1'b0}}, r_carry_char};
        end else if (r_cnt == 3'd0) begin
            e_acc = '0;
        end else begin
            e_acc = r_acc;
        end
        if (map.two_chars) begin
            wide    = {e_acc, map.char_a, map.char_b};
            sum_cnt = e_cnt + 3'd2;
        end else begin
            wide    = {7'd0, e_acc, map.char_a};
            sum_cnt = e_cnt + 3'd1;
        end
        wide_b = {r_acc, i_item.byte_value};
    end

    // next state and result
    always_comb begin
        n_acc         = r_acc;
        n_cnt         = r_cnt;
        n_carry_char  = r_carry_char;
        n_carry_valid = r_carry_valid;
        n_left        = r_left;
        n_failed      = r_failed;
        o_res         = '0;
        if (i_proc) begin
            if (i_item.kind == KIND_END) begin
                o_res.has_result    = 1'b1;
                o_res.item.end_flag = 1'b1;
                if (r_failed) begin
                    o_res.item.format_error = 1'b1;
                end else if (r_left != 3'd0) begin
                    // missing raw bytes read as zero
                    o_res.item.word_valid = 1'b1;
                    case (r_left)
                        3'd4:    o_res.item.word_value = {r_acc[3:0], 32'd0};
                        3'd3:    o_res.item.word_value = {r_acc[11:0], 24'd0};
                        3'd2:    o_res.item.word_value = {r_acc[19:0], 16'd0};
                        default: o_res.item.word_value = {r_acc[27:0], 8'd0};
                    endcase
                end else begin
                    // pad partial text word with zero characters
                    o_res.item.word_valid = (e_cnt != 3'd0);
                    case (e_cnt)
                        3'd1:    o_res.item.word_value = {e_acc[6:0], 29'd0};
                        3'd2:    o_res.item.word_value = {e_acc[13:0], 22'd0};
                        3'd3:    o_res.item.word_value = {e_acc[20:0], 15'd0};
                        3'd4:    o_res.item.word_value = {e_acc[27:0], 8'd0};
                        default: o_res.item.word_value = '0;
                    endcase
                end
                n_cnt         = '0;
                n_left        = '0;
                n_carry_valid = 1'b0;
                n_failed      = 1'b0;
            end else if (!r_failed) begin
                if (r_left != 3'd0) begin
                    // raw byte of a binary word
                    n_left = r_left - 3'd1;
                    if (r_left == 3'd1) begin
                        o_res.has_result      = 1'b1;
                        o_res.item.word_valid = 1'b1;
                        o_res.item.word_value = wide_b;
                        n_cnt                 = '0;
                    end else begin
                        n_acc = wide_b[ACC_W-1:0];
                    end
                end else begin
                    n_carry_valid = 1'b0;
                    if (map.is_lead) begin
                        if (e_cnt != 3'd0) begin
                            n_failed                = 1'b1;
                            o_res.has_result        = 1'b1;
                            o_res.item.format_error = 1'b1;
                        end else begin
                            n_acc  = {{(ACC_W-4){1'b0}}, i_item.byte_value[3:0]};
                            n_left = RAW_BYTES;
                            n_cnt  = '0;
                        end
                    end else if (sum_cnt == CNT_FULL) begin
                        o_res.has_result      = 1'b1;
                        o_res.item.word_valid = 1'b1;
                        o_res.item.word_value = {wide[34:0], 1'b0};
                        n_cnt                 = '0;
                    end else if (sum_cnt == CNT_OVER) begin
                        // second character spills into the next word
                        o_res.has_result      = 1'b1;
                        o_res.item.word_valid = 1'b1;
                        o_res.item.word_value = {wide[41:7], 1'b0};
                        n_carry_char          = wide[6:0];
                        n_carry_valid         = 1'b1;
                        n_cnt                 = '0;
                    end else begin
                        n_acc = wide[ACC_W-1:0];
                        n_cnt = sum_cnt;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_carry_valid <= 1'b0;
            r_left        <= '0;
            r_failed      <= 1'b0;
        end else begin
            r_cnt         <= n_cnt;
            r_carry_valid <= n_carry_valid;
            r_left        <= n_left;
            r_failed      <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_carry_char <= n_carry_char;
    end

endmodule

// ===== rtl/core/its_36bit_file_byte_decoder_unit.sv =====
// Rebuilds 36-bit words from a file byte stream: text bytes become 7-bit
// characters packed five to a word (low bit zero), with line-end and escape
// expansion, and lead bytes 0360-0377 open a binary word of four raw bytes.
// One transaction is accepted every cycle while o_in_stall is low; a
// transaction passes the input register, the single decode step and
// then the result register, which offers its result, if any. A binary
// lead byte arriving mid-word (a carried character counts) reports a
// format error, after which bytes are dropped until the end transaction,
// which answers with format_error set; otherwise an end flushes a padded
// word. An end always answers with end_flag set and returns the block to its reset state.
module its_36bit_file_byte_decoder_unit import fbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        out_free;
    logic        proc;
    t_engine_res res;

    // handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    fbd_word_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (proc),
        .i_item  (r_in),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && res.has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res.has_result) begin
            r_out <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // an empty result only answers an end transaction or an error
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.word_valid) |->
            ((o_out_data.word_value == '0) &&
             (o_out_data.end_flag || o_out_data.format_error)))
        else $error("empty result without end or error");

    // an error never carries a word
    a_error_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.word_valid && o_out_data.format_error))
        else $error("format error with a word");

    // every end transaction produces an end result
    a_end_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_in.kind == KIND_END)) |=> (o_out_valid && o_out_data.end_flag))
        else $error("end transaction gave no end result");
`endif

endmodule

// ===== tb/sv/its_36bit_file_byte_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module its_36bit_file_byte_decoder_unit_tb;
    import fbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned HOLD_LEN     = 150;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [63:0] MASK42       = 64'h3FF_FFFF_FFFF;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    its_36bit_file_byte_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // decoder state as the block should hold it
    logic [63:0] dec_acc      = '0;
    int unsigned dec_bits     = 0;
    logic [6:0]  dec_carry    = '0;
    bit          dec_carry_ok = 1'b0;
    int unsigned dec_raw_left = 0;
    bit          dec_failed   = 1'b0;

    // words still owed by the block, oldest first
    t_out_item   words_due[$];

    int unsigned err_cnt     = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned burst_left  = 1;
    bit          steady_send = 1'b0;
    int unsigned hold_reqs   = 0;

    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        static int unsigned seg_left = 0;
        static int unsigned stall_pct = 0;
        static int unsigned hold_left = 0;
        static int unsigned hold_served = 0;
        if (hold_served != hold_reqs) begin
            hold_served = hold_reqs;
            hold_left = HOLD_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(1, 48);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 20;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // check each accepted result transaction against the oldest word due
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (words_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, got %h", $time, o_out_data);
            end else begin
                want = words_due.pop_front();
                if (o_out_data.word_value !== want.word_value) begin
                    err_cnt++;
                    $display("%0t: word_value expected %o, got %o",
                             $time, want.word_value, o_out_data.word_value);
                end
                if (o_out_data.word_valid !== want.word_valid) begin
                    err_cnt++;
                    $display("%0t: word_valid expected %b, got %b",
                             $time, want.word_valid, o_out_data.word_valid);
                end
                if (o_out_data.end_flag !== want.end_flag) begin
                    err_cnt++;
                    $display("%0t: end_flag expected %b, got %b",
                             $time, want.end_flag, o_out_data.end_flag);
                end
                if (o_out_data.format_error !== want.format_error) begin
                    err_cnt++;
                    $display("%0t: format_error expected %b, got %b",
                             $time, want.format_error, o_out_data.format_error);
                end
            end
        end
    end

    // append one character to the gathered word
    task automatic push_char(input logic [6:0] c);
        dec_acc = ((dec_acc << 7) | {57'd0, c}) & MASK42;
        dec_bits += 7;
    endtask

    // a carried character opens the next word
    task automatic load_carry();
        if (dec_carry_ok) begin
            dec_acc = {57'd0, dec_carry};
            dec_bits = 7;
            dec_carry_ok = 1'b0;
            dec_carry = '0;
        end
    endtask

    // work out the word, if any, that one accepted transaction brings
    task automatic predict_word(input t_in_item it);
        t_out_item   res;
        bit          has;
        logic [7:0]  b;
        logic [63:0] w;
        res = '0;
        has = 1'b0;
        b = it.byte_value;
        if (it.kind == KIND_END) begin
            has = 1'b1;
            res.end_flag = 1'b1;
            if (dec_failed) begin
                res.format_error = 1'b1;
            end else if (dec_raw_left != 0) begin
                // missing raw bytes count as zero
                w = dec_acc << (8 * dec_raw_left);
                res.word_value = w[35:0];
                res.word_valid = 1'b1;
            end else begin
                load_carry();
                if (dec_bits > 0 && dec_bits < 36) begin
                    w = dec_acc << (36 - dec_bits);
                    res.word_value = w[35:0];
                    res.word_valid = 1'b1;
                end
            end
            dec_acc = '0;
            dec_bits = 0;
            dec_carry = '0;
            dec_carry_ok = 1'b0;
            dec_raw_left = 0;
            dec_failed = 1'b0;
        end else if (!dec_failed) begin
            if (dec_raw_left != 0) begin
                // raw byte of a binary word
                dec_acc = ((dec_acc << 8) | {56'd0, b}) & MASK42;
                dec_raw_left--;
                if (dec_raw_left == 0) begin
                    has = 1'b1;
                    res.word_value = dec_acc[35:0];
                    res.word_valid = 1'b1;
                    dec_acc = '0;
                    dec_bits = 0;
                end
            end else begin
                load_carry();
                if (b >= BYTE_LEAD_LO) begin
                    if (dec_bits != 0) begin
                        dec_failed = 1'b1;
                        has = 1'b1;
                        res.format_error = 1'b1;
                    end else begin
                        dec_acc = {60'd0, b[3:0]};
                        dec_raw_left = 4;
                    end
                end else begin
                    // text byte expansion
                    if (b == BYTE_LF) begin
                        push_char(CH_CR);
                        push_char(CH_LF);
                    end else if (b == BYTE_CR) begin
                        push_char(CH_LF);
                    end else if (b < BYTE_RUBOUT) begin
                        push_char(b[6:0]);
                    end else if (b == BYTE_RUBOUT) begin
                        push_char(CH_RUB);
                        push_char(CH_BEL);
                    end else if (b == BYTE_ESC_RUB) begin
                        push_char(CH_RUB);
                        push_char(CH_RUB);
                    end else if (b == BYTE_ESC_LF) begin
                        push_char(CH_RUB);
                        push_char(CH_CR);
                    end else if (b == BYTE_ESC_CR) begin
                        push_char(CH_RUB);
                        push_char(CH_LF);
                    end else if (b <= BYTE_ESC_LAST) begin
                        push_char(CH_RUB);
                        push_char(b[6:0]);
                    end else if (b == BYTE_CR_ONLY) begin
                        push_char(CH_CR);
                    end else begin
                        push_char(CH_RUB);
                    end
                    if (dec_bits == 35) begin
                        has = 1'b1;
                        w = dec_acc << 1;
                        res.word_value = w[35:0];
                        res.word_valid = 1'b1;
                        dec_acc = '0;
                        dec_bits = 0;
                    end else if (dec_bits == 42) begin
                        // sixth character spills into the next word
                        dec_carry = dec_acc[6:0];
                        dec_carry_ok = 1'b1;
                        w = (dec_acc >> 7) << 1;
                        res.word_value = w[35:0];
                        res.word_valid = 1'b1;
                        has = 1'b1;
                        dec_acc = '0;
                        dec_bits = 0;
                    end
                end
            end
        end
        if (has)
            words_due.push_back(res);
    endtask

    // offer one input transaction, wait for acceptance, then maybe idle
    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_word(it);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && !steady_send) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it.kind = KIND_BYTE;
        it.byte_value = b;
        send_item(it);
    endtask

    task automatic send_end();
        t_in_item it;
        it.kind = KIND_END;
        it.byte_value = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    // end of stream with nothing gathered
    task automatic test_empty_end();
        send_end();
    endtask

    // line ends, rubout and escapes, spill of a character and its flush
    task automatic test_text_mapping();
        send_byte(BYTE_LF);
        send_byte(BYTE_CR);
        send_byte(BYTE_RUBOUT);
        send_byte(BYTE_ESC_RUB);
        send_byte(BYTE_ESC_LF);
        send_byte(BYTE_ESC_CR);
        send_end();
    endtask

    // a spilled character counts as mid-word for a lead byte
    task automatic test_carry_then_lead();
        send_byte(BYTE_CR_ONLY);
        send_byte(BYTE_RUB_ONLY);
        send_byte(8'o000);
        send_byte(8'o176);
        send_byte(8'o200);
        send_byte(BYTE_LEAD_LO);
        send_byte(8'h41);
        send_end();
    endtask

    // full binary word and one cut short by the end transaction
    task automatic test_binary_words();
        send_byte(BYTE_LEAD_LO);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'o377);
        send_byte(8'h12);
        send_end();
    endtask

    // partial text word padded at end of stream
    task automatic test_partial_text();
        send_byte(8'h41);
        send_byte(BYTE_ESC_LAST);
        send_end();
    endtask

    // mostly well-formed streams, some noise and stray lead bytes
    task automatic test_random_stream();
        t_in_item    it;
        int unsigned used;
        int unsigned r;
        bit          lead_ok;
        used = 0;
        while (used < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            it.kind = KIND_BYTE;
            it.byte_value = 8'($urandom_range(0, 255));
            lead_ok = (dec_bits == 0 && !dec_carry_ok && dec_raw_left == 0);
            if (dec_failed) begin
                if (r < 30)
                    it.kind = KIND_END;
            end else if (r < 2) begin
                it.kind = KIND_END;
            end else if (dec_raw_left == 0 && r >= 7) begin
                if (r < 14 && (lead_ok || r == 13)) begin
                    it.byte_value = 8'($urandom_range(240, 255));
                end else if (r < 40) begin
                    case ($urandom_range(0, 11))
                        0:       it.byte_value = BYTE_LF;
                        1:       it.byte_value = BYTE_CR;
                        2:       it.byte_value = BYTE_RUBOUT;
                        3:       it.byte_value = BYTE_ESC_RUB;
                        4:       it.byte_value = BYTE_ESC_LF;
                        5:       it.byte_value = BYTE_ESC_CR;
                        6:       it.byte_value = BYTE_ESC_LAST;
                        7:       it.byte_value = BYTE_CR_ONLY;
                        8:       it.byte_value = BYTE_RUB_ONLY;
                        9:       it.byte_value = 8'o200;
                        10:      it.byte_value = 8'o000;
                        default: it.byte_value = 8'o176;
                    endcase
                end else begin
                    it.byte_value = 8'($urandom_range(0, 239));
                end
            end
            if (!dec_failed || it.kind == KIND_END)
                used++;
            send_item(it);
        end
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_backpressure();
        steady_send = 1'b1;
        hold_reqs++;
        repeat (60)
            send_byte(8'($urandom_range(0, 126)));
        send_end();
        steady_send = 1'b0;
    endtask

    initial begin
        repeat (11)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_end();
        test_text_mapping();
        test_carry_then_lead();
        test_binary_words();
        test_partial_text();
        test_random_stream();
        test_backpressure();

        i_in_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);

        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fbd_pkg.sv
rtl/core/fbd_char_map.sv
rtl/core/fbd_word_engine.sv
rtl/core/its_36bit_file_byte_decoder_unit.sv
tb/sv/its_36bit_file_byte_decoder_unit_tb.sv
